>>> hdl/matrix_multiply_engine_defines.svh
// Assertion macros shared by the matrix multiply engine checkers.
// Expects i_clk and i_rst_n to be visible where a macro is used.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mme_pkg.sv
// Package for the matrix multiply engine: field widths, command codes,
// and the control struct of the multiply-accumulate unit. No dependencies.
`timescale 1ns / 1ps

package mme_pkg;

    // Field widths
    localparam int SIZE_W       = 5;
    localparam int IDX_W        = 4;
    localparam int ELEM_W       = 16;
    localparam int MUL_W        = 2 * ELEM_W;
    localparam int PROD_W       = 48;
    localparam int CMD_W        = 2;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 56;

    // Active size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Command codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_READ_C = 2'd2
    } t_cmd;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic enable;
    } t_mac_ctl;

endpackage

>>> hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: command decode, sequencer,
// A and B stores, shared MAC and output register. Depends on mme_pkg,
// mme_ram and mme_mac.
//
// Input stream: tuser carries the command (load A, load B, read C); tdata
// carries row, col and a Q8.8 value. A load writes one element and gives no
// result; an index at or beyond the active size drops the load.
// Output stream: one transfer per read with row, col and the Q32.16 dot
// product; tuser flags an index at or beyond the active size (zero product).
// Config channel: writes the active size, taken at any time; change it only
// while idle. A load is written on its accept. A read steps the shared MAC
// through row and column up to the effective size (the active size capped
// at MAX_DIM); a drain state then adds the last registered store read and
// a done state loads the output register. An out-of-range read goes from
// the accept straight to the done state.
// Reset clears the sequencer and output valid and sets the active size to
// 16; the stores hold nothing defined until written. When the receiver
// stalls, the result waits in the output register and the next command is
// still taken; a second read waits at its final step until the first
// result is transferred.
`timescale 1ns / 1ps

module matrix_multiply_engine #(
    parameter int MAX_DIM = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: row [3:0], col [7:4], value [23:8]
    input  logic [mme_pkg::IN_TDATA_W-1:0]        i_s_tdata,
    // tuser: command [1:0]
    input  logic [mme_pkg::CMD_W-1:0]             i_s_tuser,
    // Output stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata: out_row [3:0], out_col [7:4], product [55:8]
    output logic [mme_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // tuser: status [0]
    output logic                                  o_m_tuser,
    // Config channel: active size
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mme_pkg::SIZE_W-1:0]            i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    logic [mme_pkg::SIZE_W-1:0]         r_active_size;
    logic [mme_pkg::SIZE_W-1:0]         r_k, n_k;
    logic [ADDR_W-1:0]                  r_a_addr, n_a_addr;
    logic [ADDR_W-1:0]                  r_b_addr, n_b_addr;
    logic [mme_pkg::IDX_W-1:0]          r_row, r_col;
    logic                               r_err;
    logic                               r_issue_vld;
    logic                               r_out_vld, n_out_vld;
    logic [mme_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic                               r_out_err;

    logic [mme_pkg::IDX_W-1:0]          w_row, w_col;
    logic [mme_pkg::ELEM_W-1:0]         w_value;
    mme_pkg::t_cmd                      w_cmd;
    logic [mme_pkg::SIZE_W-1:0]         w_eff;
    logic                               w_inside;
    logic                               w_accept;
    logic                               w_read_acc;
    logic                               w_wr_a, w_wr_b;
    logic [ADDR_W-1:0]                  w_wr_addr;
    logic                               w_last;
    logic                               w_out_load;
    logic [mme_pkg::ELEM_W-1:0]         w_rd_a, w_rd_b;
    logic signed [mme_pkg::PROD_W-1:0]  w_acc;
    mme_pkg::t_mac_ctl                  w_mac_ctl;

    // Unpack the input transfer
    assign w_row   = i_s_tdata[3:0];
    assign w_col   = i_s_tdata[7:4];
    assign w_value = i_s_tdata[23:8];
    assign w_cmd   = mme_pkg::t_cmd'(i_s_tuser);

    // Effective size: active size capped at the store dimension
    assign w_eff    = (32'(r_active_size) > MAX_DIM) ? mme_pkg::SIZE_W'(MAX_DIM)
                                                     : r_active_size;
    assign w_inside = (mme_pkg::SIZE_W'(w_row) < w_eff) && (mme_pkg::SIZE_W'(w_col) < w_eff);

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Decode the accepted command
    always_comb begin
        w_wr_a     = 1'b0;
        w_wr_b     = 1'b0;
        w_read_acc = 1'b0;
        case (w_cmd)
            mme_pkg::CMD_LOAD_A: w_wr_a     = w_accept && w_inside;
            mme_pkg::CMD_LOAD_B: w_wr_b     = w_accept && w_inside;
            mme_pkg::CMD_READ_C: w_read_acc = w_accept;
            default: ;
        endcase
    end

    assign w_wr_addr = ADDR_W'(32'(w_row) * MAX_DIM + 32'(w_col));

    // Config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= mme_pkg::SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active_size <= i_cfg_data;
        end
    end

    // Sequencer: step row of A and column of B through the shared MAC
    assign w_last     = (r_k == w_eff - mme_pkg::SIZE_W'(1));
    assign w_out_load = (r_state == ST_DONE) && (!r_out_vld || i_m_tready);

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        case (r_state)
            ST_IDLE: begin
                if (w_read_acc) begin
                    n_k      = '0;
                    n_a_addr = ADDR_W'(32'(w_row) * MAX_DIM);
                    n_b_addr = ADDR_W'(w_col);
                    n_state  = w_inside ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                n_k      = r_k + mme_pkg::SIZE_W'(1);
                n_a_addr = r_a_addr + ADDR_W'(1);
                n_b_addr = r_b_addr + ADDR_W'(MAX_DIM);
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue_vld <= (r_state == ST_RUN);
        end
    end

    // Hold the read's index and range flag
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
        if (w_read_acc) begin
            r_row <= w_row;
            r_col <= w_col;
            r_err <= !w_inside;
        end
    end

    // Stores for A and B
    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_a),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_value),
        .i_rd_addr (r_a_addr),
        .o_rd_data (w_rd_a)
    );

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_b),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_value),
        .i_rd_addr (r_b_addr),
        .o_rd_data (w_rd_b)
    );

    // Shared multiply-accumulate: clear on read, add each term read back
    assign w_mac_ctl.clear  = w_read_acc;
    assign w_mac_ctl.enable = r_issue_vld;

    mme_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   ($signed(w_rd_a)),
        .i_b   ($signed(w_rd_b)),
        .o_acc (w_acc)
    );

    // Output register: load the finished sum, drop valid on transfer
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_out_load) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {(r_err ? mme_pkg::PROD_W'(0) : w_acc), r_col, r_row};
            r_out_err  <= r_err;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;

endmodule

>>> hdl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/mme_mac.sv
// Shared multiply-accumulate unit: one signed Q8.8 product per enabled cycle
// into a 48-bit Q32.16 accumulator. Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_mac (
    input  logic                                   i_clk,
    input  mme_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [mme_pkg::ELEM_W-1:0]      i_a,
    input  logic signed [mme_pkg::ELEM_W-1:0]      i_b,
    output logic signed [mme_pkg::PROD_W-1:0]      o_acc
);

    logic signed [mme_pkg::MUL_W-1:0]  w_mul;
    logic signed [mme_pkg::PROD_W-1:0] r_acc;
    logic signed [mme_pkg::PROD_W-1:0] n_acc;

    assign w_mul = i_a * i_b;

    // Clear at the start of a dot product, add one term per enabled cycle
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.enable) begin
            n_acc = r_acc + mme_pkg::PROD_W'(w_mul);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> hdl/mme_checker.sv
// Port-level checker for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_defines.svh.
`timescale 1ns / 1ps
`include "matrix_multiply_engine_defines.svh"

module mme_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [mme_pkg::CMD_W-1:0]          i_s_tuser,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [mme_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic                               o_m_tuser
);

    // A stalled result stays offered
    `MME_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")

    // A read transfer keeps the input side busy in the next cycle
    `MME_ASSERT_NEXT(a_read_busy, i_s_tvalid && o_s_tready && (i_s_tuser == mme_pkg::CMD_READ_C), !o_s_tready, "input ready right after a read")

    // An out-of-range result carries a zero product
    `MME_ASSERT(a_err_zero, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[55:8] == '0), "error result with nonzero product")

    // A new result only follows a busy cycle of the sequencer
    `MME_ASSERT(a_out_after_busy, $rose(o_m_tvalid) |-> $past(!o_s_tready), "result appeared without a read in flight")

endmodule

bind matrix_multiply_engine mme_checker u_checker (.*);
